// ===== hw/rtl/ordered_fifo_list_engine_macros.svh =====
// Assertion macros used by the checker file ofl_checker.sv.
`ifndef ORDERED_FIFO_LIST_ENGINE_MACROS_SVH
`define ORDERED_FIFO_LIST_ENGINE_MACROS_SVH
// Implication checked on every rising clock edge outside reset.
`define OFL_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
// Implication with the consequent in the following cycle.
`define OFL_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`endif

// ===== hw/rtl/ofl_pkg.sv =====
//------------------------------------------------------------------------------
// ofl_pkg
// Types and codes shared by the ordered list engine and its checker.
//------------------------------------------------------------------------------
`default_nettype none
package ofl_pkg;
  localparam logic [1:0] OP_PUSH   = 2'd0;
  localparam logic [1:0] OP_INSERT = 2'd1;
  localparam logic [1:0] OP_POP    = 2'd2;
  localparam logic [1:0] OP_REMOVE = 2'd3;

  localparam logic [1:0] ST_DONE  = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;

  typedef struct packed {
    logic [1:0]         opcode;
    logic signed [31:0] operand_value;
  } req_t;

  typedef struct packed {
    logic [1:0]         status;
    logic signed [31:0] removed_value;
    logic [4:0]         entries_held;
  } rsp_t;
endpackage
`default_nettype wire

// ===== hw/rtl/ordered_fifo_list_engine.sv =====
//------------------------------------------------------------------------------
// ordered_fifo_list_engine
// Bounded ordered list with push, ordered insert, pop and remove by key.
//------------------------------------------------------------------------------
// Requests arrive on in_valid/in_ready as req_t; each gives one rsp_t on
// out_valid/out_ready. The list lives in one synchronous memory of CAPACITY
// entries. A request walks the list with a sequencer: one read per cycle to
// find the place, then one read and one write per cycle to shift entries.
// A push writes at the tail; a pop or remove scans to its entry and shifts
// the later entries toward the head; an ordered insert scans to its place
// and shifts entries toward the tail. A refused push or insert, and a pop
// or remove on an empty list, goes straight to its result without a walk.
// The next request is taken in the cycle after the result is registered,
// even while the receiver stalls it; that request then waits with its result
// until the output register is free.
// Reset empties the list at once; no clearing pass is needed because only
// entries below the count are used. A stalled result holds its value.
//------------------------------------------------------------------------------
`default_nettype none
module ordered_fifo_list_engine
  import ofl_pkg::*;
#(
  parameter int CAPACITY   = 16,
  parameter int VALUE_BITS = 32
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic in_valid,
  output logic      in_ready,
  input  wire req_t in_data,
  output logic      out_valid,
  input  wire logic out_ready,
  output rsp_t      out_data
);
  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW = $clog2(CAPACITY + 1);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_SCAN  = 3'd1;  // compare entry idx, read issued for the next
  localparam logic [2:0] S_SHUP  = 3'd2;  // shift toward tail for insert
  localparam logic [2:0] S_SHDN  = 3'd3;  // shift toward head for removal
  localparam logic [2:0] S_DONE  = 3'd4;

  logic [VALUE_BITS-1:0] mem [CAPACITY];
  logic [VALUE_BITS-1:0] rd_data;
  logic [AW-1:0]         rd_addr;
  logic                  rd_en;
  logic                  wr_en;
  logic [AW-1:0]         wr_addr;
  logic [VALUE_BITS-1:0] wr_data;

  logic [2:0]            state;
  logic [CW-1:0]         count;
  logic [CW-1:0]         idx;    // entry compared in S_SCAN, written in S_SHUP/S_SHDN
  logic [CW-1:0]         pos;
  logic [1:0]            op;
  logic [VALUE_BITS-1:0] val;
  logic [VALUE_BITS-1:0] found;
  logic                  hit;
  logic                  refused;

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    if (rd_en) rd_data <= mem[rd_addr];
  end

  logic [VALUE_BITS-1:0] v_in;
  assign v_in = VALUE_BITS'(signed'(in_data.operand_value));

  logic is_add;
  logic is_full;
  assign is_add  = (in_data.opcode == OP_PUSH) || (in_data.opcode == OP_INSERT);
  assign is_full = (count == CW'(CAPACITY));

  logic out_free;
  assign out_free = !out_valid || out_ready;
  assign in_ready = (state == S_IDLE) && !rst;

  logic gt;
  assign gt = $signed(rd_data) > $signed(val);

  always_comb begin
    rd_en   = 1'b0;
    rd_addr = '0;
    wr_en   = 1'b0;
    wr_addr = '0;
    wr_data = val;
    unique case (state)
      S_IDLE: begin
        rd_en   = 1'b1;
        rd_addr = '0;
      end
      S_SCAN: begin
        rd_en = 1'b1;
        // An insert that has found its place starts the shift at the tail.
        if (op == OP_INSERT && (gt || idx + CW'(1) == count))
          rd_addr = AW'(count - CW'(1));
        else
          rd_addr = AW'(idx + CW'(1));
      end
      S_SHUP: begin
        // Move entry idx-1 to idx, reading the next one down; at pos, write the new value.
        if (idx > pos) begin
          wr_en   = 1'b1;
          wr_addr = AW'(idx);
          wr_data = rd_data;
          rd_en   = 1'b1;
          rd_addr = AW'(idx - CW'(2));
        end else begin
          wr_en   = 1'b1;
          wr_addr = AW'(pos);
          wr_data = val;
        end
      end
      S_SHDN: begin
        // rd_data holds entry idx+1, written down to idx.
        wr_en   = 1'b1;
        wr_addr = AW'(idx);
        wr_data = rd_data;
        rd_en   = 1'b1;
        rd_addr = AW'(idx + CW'(2));
      end
      S_DONE: ;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      if (state == S_DONE && out_free) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            op      <= in_data.opcode;
            val     <= v_in;
            hit     <= 1'b0;
            found   <= '0;
            refused <= is_add && is_full;
            if (is_add && is_full) begin
              idx   <= '0;
              state <= S_DONE;
            end else if (in_data.opcode == OP_PUSH ||
                         (in_data.opcode == OP_INSERT && count == '0)) begin
              pos   <= count;
              idx   <= count;
              state <= S_SHUP;
            end else if (count == '0) begin
              idx   <= '0;
              state <= S_DONE;
            end else begin
              idx   <= '0;
              state <= S_SCAN;
            end
          end
        end
        S_SCAN: begin
          // rd_data is entry idx.
          if (op == OP_INSERT) begin
            if (gt || idx + CW'(1) == count) begin
              pos   <= gt ? idx : count;
              idx   <= count;
              state <= S_SHUP;
            end else idx <= idx + CW'(1);
          end else if (op == OP_POP || rd_data == val) begin
            found <= rd_data;
            hit   <= 1'b1;
            if (idx + CW'(1) == count) begin
              count <= count - CW'(1);
              state <= S_DONE;
            end else state <= S_SHDN;
          end else if (idx + CW'(1) == count) begin
            state <= S_DONE;
          end else idx <= idx + CW'(1);
        end
        S_SHUP: begin
          if (idx > pos) idx <= idx - CW'(1);
          else begin
            count <= count + CW'(1);
            state <= S_DONE;
          end
        end
        S_SHDN: begin
          idx <= idx + CW'(1);
          if (idx + CW'(2) == count) begin
            count <= count - CW'(1);
            state <= S_DONE;
          end
        end
        S_DONE: begin
          if (out_free) begin
            if (op == OP_PUSH || op == OP_INSERT) begin
              out_data.status        <= refused ? ST_FULL : ST_DONE;
              out_data.removed_value <= '0;
            end else begin
              out_data.status        <= hit ? ST_DONE : ST_EMPTY;
              out_data.removed_value <= 32'(signed'(found));
            end
            out_data.entries_held <= 5'(count);
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

// ===== hw/rtl/ofl_checker.sv =====
//------------------------------------------------------------------------------
// ofl_checker
// Port-level checks on the ordered list engine.
//------------------------------------------------------------------------------
`default_nettype none
`include "ordered_fifo_list_engine_macros.svh"
module ofl_checker
  import ofl_pkg::*;
#(
  parameter int CAPACITY = 16
) (
  input wire logic clk,
  input wire logic rst,
  input wire logic in_valid,
  input wire logic in_ready,
  input wire req_t in_data,
  input wire logic out_valid,
  input wire logic out_ready,
  input wire rsp_t out_data
);
  `OFL_ASSERT_NEXT(a_stall_hold, clk, rst, out_valid && !out_ready, out_valid && $stable(out_data), "result changed while stalled")
  `OFL_ASSERT_IMP(a_status_code, clk, rst, out_valid, out_data.status != 2'd3, "bad status code")
  `OFL_ASSERT_IMP(a_fail_zero, clk, rst, out_valid && out_data.status != ST_DONE, out_data.removed_value == '0, "failed request removed a value")
  `OFL_ASSERT_IMP(a_full_count, clk, rst, out_valid && out_data.status == ST_FULL, out_data.entries_held == 5'(CAPACITY), "full refusal without full list")
endmodule

bind ordered_fifo_list_engine ofl_checker #(.CAPACITY(CAPACITY)) u_ofl_checker (
  .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
  .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
);
`default_nettype wire

// ===== test/tb_ordered_fifo_list_engine.sv =====
//------------------------------------------------------------------------------
// tb_ordered_fifo_list_engine
// Self-checking bench for the ordered list engine: directed and random
// requests, a list model that predicts each response, random idling on both
// channels and a field-by-field compare in order of arrival.
//------------------------------------------------------------------------------
`default_nettype none
module tb_ordered_fifo_list_engine;
  import ofl_pkg::*;

  localparam int DEPTH = 16;
  localparam int CYCLE_LIMIT = 400000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  req_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  rsp_t out_data;

  req_t pending_reqs[$];
  rsp_t expected_rsps[$];
  logic signed [31:0] list_vals[$];
  int error_count = 0;
  int cycle_count = 0;
  int send_gap = 0;
  int recv_gap = 0;
  bit hold_sender = 1'b0;

  ordered_fifo_list_engine i_dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 45) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(5, 30);
  endfunction

  // Applies one request to the list model and returns the response.
  function automatic rsp_t apply_list_op(req_t rq);
    rsp_t rs;
    int pos;
    rs = '0;
    rs.status = ST_DONE;
    case (rq.opcode)
      OP_PUSH, OP_INSERT: begin
        if (list_vals.size() >= DEPTH) begin
          rs.status = ST_FULL;
        end else begin
          pos = list_vals.size();
          if (rq.opcode == OP_INSERT) begin
            for (int i = 0; i < list_vals.size(); i++) begin
              if (rq.operand_value < list_vals[i]) begin
                pos = i;
                break;
              end
            end
          end
          list_vals.insert(pos, rq.operand_value);
        end
      end
      OP_POP: begin
        if (list_vals.size() == 0) begin
          rs.status = ST_EMPTY;
        end else begin
          rs.removed_value = list_vals.pop_front();
        end
      end
      default: begin
        rs.status = ST_EMPTY;
        for (int i = 0; i < list_vals.size(); i++) begin
          if (list_vals[i] == rq.operand_value) begin
            rs.removed_value = list_vals[i];
            list_vals.delete(i);
            rs.status = ST_DONE;
            break;
          end
        end
      end
    endcase
    rs.entries_held = 5'(list_vals.size());
    return rs;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch on %s: got %h, expected %h", what, got, want);
    error_count++;
  endtask

  function automatic req_t make_req(logic [1:0] op, logic signed [31:0] v);
    req_t rq;
    rq.opcode = op;
    rq.operand_value = v;
    return rq;
  endfunction

  function automatic logic signed [31:0] rand_value();
    int r;
    r = $urandom_range(0, 9);
    if (r < 6) return $signed(32'($urandom_range(0, 12))) - 6;
    if (r < 8) return $signed($urandom());
    return (r == 8) ? 32'sh7fffffff : 32'sh80000000;
  endfunction

  // Driver.
  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && in_ready) begin
        expected_rsps.push_back(apply_list_op(in_data));
      end
      if (!in_valid || in_ready) begin
        if (send_gap > 0) begin
          in_valid <= 1'b0;
          send_gap <= send_gap - 1;
        end else if (pending_reqs.size() > 0 && !hold_sender) begin
          in_valid <= 1'b1;
          in_data <= pending_reqs.pop_front();
          send_gap <= pick_gap();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor.
  always @(posedge clk) begin
    rsp_t want;
    if (!rst) begin
      if (out_valid && out_ready) begin
        if (expected_rsps.size() == 0) begin
          report_mismatch("unexpected response", 32'(out_data), 32'hx);
        end else begin
          want = expected_rsps.pop_front();
          if (out_data.status !== want.status)
            report_mismatch("status", 32'(out_data.status), 32'(want.status));
          if (out_data.removed_value !== want.removed_value)
            report_mismatch("removed_value", out_data.removed_value,
                            want.removed_value);
          if (out_data.entries_held !== want.entries_held)
            report_mismatch("entries_held", 32'(out_data.entries_held),
                            32'(want.entries_held));
        end
      end
      if (recv_gap > 0) begin
        out_ready <= 1'b0;
        recv_gap <= recv_gap - 1;
      end else begin
        out_ready <= 1'b1;
        if (out_valid) recv_gap <= pick_gap();
      end
    end
  end

  // Watchdog.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  initial begin
    int r;
    // Directed: empty cases, extremes, order with ties, fill past capacity.
    pending_reqs.push_back(make_req(OP_POP, 0));
    pending_reqs.push_back(make_req(OP_REMOVE, 32'sh80000000));
    pending_reqs.push_back(make_req(OP_INSERT, 5));
    pending_reqs.push_back(make_req(OP_INSERT, 32'sh80000000));
    pending_reqs.push_back(make_req(OP_INSERT, 32'sh7fffffff));
    pending_reqs.push_back(make_req(OP_INSERT, 5));
    pending_reqs.push_back(make_req(OP_INSERT, -1));
    pending_reqs.push_back(make_req(OP_REMOVE, 5));
    pending_reqs.push_back(make_req(OP_REMOVE, 77));
    pending_reqs.push_back(make_req(OP_POP, 0));
    for (int i = 0; i < 14; i++) pending_reqs.push_back(make_req(OP_PUSH, -1 - i));
    pending_reqs.push_back(make_req(OP_INSERT, 0));
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    wait (pending_reqs.size() == 0);
    // Let every outstanding response drain once before the random part.
    @(posedge clk);
    hold_sender <= 1'b1;
    wait (expected_rsps.size() == 0 && !in_valid);
    @(posedge clk);
    hold_sender <= 1'b0;
    for (int i = 0; i < 850; i++) begin
      r = $urandom_range(0, 99);
      if (r < 25) pending_reqs.push_back(make_req(OP_PUSH, rand_value()));
      else if (r < 50) pending_reqs.push_back(make_req(OP_INSERT, rand_value()));
      else if (r < 75) pending_reqs.push_back(make_req(OP_POP, rand_value()));
      else pending_reqs.push_back(make_req(OP_REMOVE, rand_value()));
    end
    wait (pending_reqs.size() == 0);
    @(posedge clk);
    wait (expected_rsps.size() == 0 && !in_valid);
    repeat (50) @(posedge clk);
    if (error_count == 0 && expected_rsps.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end
endmodule
`default_nettype wire
